// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed under reset guard");

// Assertion that is checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== design/pst_pkg.sv =====
// Package of the photogate speed timer: widths, reset values, register indexes
package pst_pkg;

    // Configuration register widths and reset values
    localparam int THR_W       = 10;
    localparam int SPACING_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [THR_W-1:0]     THR1_RST    = THR_W'(720);
    localparam logic [THR_W-1:0]     THR2_RST    = THR_W'(450);
    localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'(200);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR1    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR2    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd2;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;

    // Result field widths
    localparam int TRANSIT_W = 32;
    localparam int SPEED_W   = 26;
    localparam int ACCEL_W   = 36;
    localparam int OUT_FIELDS_W = TRANSIT_W + SPEED_W + ACCEL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Dividend width of the shared divider
    localparam int DIV_W = ACCEL_W;

    // Scale factor mm/s per mm/ms
    localparam int KILO = 1000;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/pst_div.sv =====
// Shared restoring divider, one quotient bit per cycle
module pst_div #(
    parameter int TIME_BITS = pst_pkg::TIME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pst_pkg::DIV_W-1:0] i_dividend,
    input  logic [TIME_BITS-1:0]      i_divisor,
    output pst_pkg::t_div_stat        o_stat,
    output logic [pst_pkg::DIV_W-1:0] o_quot
);
    import pst_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    logic [TIME_BITS-1:0] r_dvs, n_dvs;
    logic [TIME_BITS:0]   trial;
    logic                 fits;

    // One shift-compare-subtract step
    always_comb begin
        trial  = {r_rem, r_quo[DIV_W-1]};
        fits   = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_W-2:0], fits};
            n_rem = fits ? TIME_BITS'(trial - {1'b0, r_dvs}) : TIME_BITS'(trial);
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

// ===== design/photogate_speed_timer_core.sv =====
// Top level of the photogate speed timer: gate logic, sequencer, output register
//
// Channel | Direction | Payload (low bit first)                 | Handshake
// s       | in        | tdata: first_sample, second_sample      | i_s_tvalid / o_s_tready
// m       | out       | tdata: transit, speed, accel; tuser: zt | o_m_tvalid / i_m_tready
// cfg     | in        | index, data                             | i_cfg_we, no wait
//
// A request with no detection leaves the sequencer idle; a zero transit passes through S_DONE only.
// A detection with nonzero transit runs S_START1, S_WAIT1, S_START2, S_WAIT2, S_DONE,
// waiting on the shared divider that produces one quotient bit per cycle for each quotient.
// Reset is synchronous and active low; it restores the control and configuration registers and disarms.
// A held result in the output register does not stop new requests; only the
// load of a new result waits for the output register to empty.
module photogate_speed_timer_core #(
    parameter int SAMPLE_BITS = pst_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = pst_pkg::TIME_BITS_DEF,
    parameter int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // fields: first_sample, second_sample
    input  logic [IN_TDATA_W-1:0]           i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // fields: transit_ms, speed_mm_s, accel_mm_s2
    output logic [pst_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // fields: zero_time
    output logic [0:0]                      o_m_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pst_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START1 = 3'd1;
    localparam logic [2:0] S_WAIT1  = 3'd2;
    localparam logic [2:0] S_START2 = 3'd3;
    localparam logic [2:0] S_WAIT2  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [THR_W-1:0]       r_thr1, r_thr2;
    logic [SPACING_W-1:0]   r_spacing;
    logic                   r_armed, n_armed;
    logic [TIME_BITS-1:0]   r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0]   r_t, n_t;
    logic [SPEED_W-1:0]     r_speed, n_speed;
    logic [ACCEL_W-1:0]     r_accel, n_accel;
    logic                   r_zero, n_zero;
    logic                   r_m_valid, n_m_valid;
    logic [OUT_FIELDS_W-1:0] r_m_data, n_m_data;
    logic                   r_m_zero, n_m_zero;

    logic [SAMPLE_BITS-1:0] s1, s2;
    logic                   s1_hit, s2_hit, arm_now, armed_mid, fire, accept;
    logic [TIME_BITS-1:0]   elapsed_mid;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [DIV_W-1:0]       div_quot;
    t_div_stat              div_stat;

    assign accept = i_s_tvalid && o_s_tready;
    assign s1     = i_s_tdata[SAMPLE_BITS-1:0];
    assign s2     = i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Gate tests and tick counter for one sample pair
    always_comb begin
        s1_hit    = CMP_W'(s1) < CMP_W'(r_thr1);
        s2_hit    = CMP_W'(s2) < CMP_W'(r_thr2);
        arm_now   = !r_armed && s1_hit;
        armed_mid = r_armed || arm_now;
        if (arm_now) begin
            elapsed_mid = '0;
        end else if (r_armed && (r_elapsed != '1)) begin
            elapsed_mid = r_elapsed + TIME_BITS'(1);
        end else begin
            elapsed_mid = r_elapsed;
        end
        fire = armed_mid && s2_hit;
    end

    // Divider operands: spacing*1000 first, then speed*1000
    always_comb begin
        div_start = (r_state == S_START1) || (r_state == S_START2);
        if (r_state == S_START2) begin
            div_dividend = DIV_W'(r_speed) * DIV_W'(KILO);
        end else begin
            div_dividend = DIV_W'(SPEED_W'(r_spacing) * SPEED_W'(KILO));
        end
    end

    pst_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_t),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Sequencer and result assembly
    always_comb begin
        n_state   = r_state;
        n_armed   = r_armed;
        n_elapsed = r_elapsed;
        n_t       = r_t;
        n_speed   = r_speed;
        n_accel   = r_accel;
        n_zero    = r_zero;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        n_m_zero  = r_m_zero;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_armed   = armed_mid && !fire;
                    n_elapsed = elapsed_mid;
                    if (fire) begin
                        n_t = elapsed_mid;
                        if (elapsed_mid == '0) begin
                            n_speed = '1;
                            n_accel = '1;
                            n_zero  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_zero  = 1'b0;
                            n_state = S_START1;
                        end
                    end
                end
            end
            S_START1: n_state = S_WAIT1;
            S_WAIT1: begin
                if (div_stat.done) begin
                    n_speed = div_quot[SPEED_W-1:0];
                    n_state = S_START2;
                end
            end
            S_START2: n_state = S_WAIT2;
            S_WAIT2: begin
                if (div_stat.done) begin
                    n_accel = div_quot[ACCEL_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_accel, r_speed, TRANSIT_W'(r_t)};
                    n_m_zero  = r_zero;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_armed   <= 1'b0;
            r_elapsed <= '0;
            r_m_valid <= 1'b0;
            r_thr1    <= THR1_RST;
            r_thr2    <= THR2_RST;
            r_spacing <= SPACING_RST;
        end else begin
            r_state   <= n_state;
            r_armed   <= n_armed;
            r_elapsed <= n_elapsed;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_THR1:    r_thr1    <= i_cfg_data[THR_W-1:0];
                    REG_THR2:    r_thr2    <= i_cfg_data[THR_W-1:0];
                    REG_SPACING: r_spacing <= i_cfg_data[SPACING_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_speed  <= n_speed;
        r_accel  <= n_accel;
        r_zero   <= n_zero;
        r_m_data <= n_m_data;
        r_m_zero <= n_m_zero;
    end

    assign o_s_tready = (r_state == S_IDLE) && !div_stat.busy;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_m_data);
    assign o_m_tuser  = r_m_zero;

endmodule

// ===== design/pst_checker.sv =====
// Port-level checker of the photogate speed timer and its bind
`include "assert_macros.svh"

module pst_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic [pst_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]                      o_m_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready
);
    import pst_pkg::*;

    logic zero_ok;
    logic nonzero_ok;

    // A zero-transit result carries zero time and saturated quotients
    assign zero_ok = (o_m_tdata[TRANSIT_W-1:0] == '0)
        && (o_m_tdata[TRANSIT_W+SPEED_W-1:TRANSIT_W] == '1)
        && (o_m_tdata[OUT_FIELDS_W-1:TRANSIT_W+SPEED_W] == '1);
    // Without the flag the transit time is never zero
    assign nonzero_ok = o_m_tdata[TRANSIT_W-1:0] != '0;

    `ASSERT_RST(a_valid_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `ASSERT_RST(a_zero_shape, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0] |-> zero_ok)
    `ASSERT_RST(a_nonzero_time, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0] |-> nonzero_ok)
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind photogate_speed_timer_core pst_checker u_pst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

// ===== verif/photogate_checker.sv =====
// Checker of the photogate speed timer: tracks gate state, predicts crossings, compares results
module photogate_checker #(
    parameter int SMP_W = pst_pkg::SAMPLE_BITS_DEF,
    parameter int IN_W  = ((2 * SMP_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // fields: first_sample, second_sample
    input  logic [IN_W-1:0]                 i_s_tdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // fields: transit_ms, speed_mm_s, accel_mm_s2
    input  logic [pst_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    // fields: zero_time
    input  logic [0:0]                      i_m_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRANSIT_W = pst_pkg::TRANSIT_W;
    localparam int SPEED_W   = pst_pkg::SPEED_W;
    localparam int ACCEL_W   = pst_pkg::ACCEL_W;

    typedef struct packed {
        logic [TRANSIT_W-1:0] transit_ms;
        logic [SPEED_W-1:0]   speed_mm_s;
        logic [ACCEL_W-1:0]   accel_mm_s2;
        logic                 zero_time;
    } t_crossing;

    // crossings timed but not yet seen on the result channel, oldest first
    t_crossing crossings_due[$];

    // shadow of the configuration registers
    logic [pst_pkg::THR_W-1:0]     thr_first;
    logic [pst_pkg::THR_W-1:0]     thr_second;
    logic [pst_pkg::SPACING_W-1:0] spacing_mm;

    // shadow of the gate state
    logic                                armed;
    logic [pst_pkg::TIME_BITS_DEF-1:0]   ticks;

    // One millisecond tick: first gate arms, counter runs, second gate fires
    function automatic void time_crossing(input logic [SMP_W-1:0] first,
                                          input logic [SMP_W-1:0] second);
        t_crossing   r;
        bit [63:0]   spd;
        bit [63:0]   acc;
        if (!armed && first < thr_first) begin
            armed = 1'b1;
            ticks = '0;
        end else if (armed && ticks != '1) begin
            ticks = ticks + 1'b1;
        end
        if (armed && second < thr_second) begin
            armed = 1'b0;
            if (ticks == '0) begin
                // zero transit saturates both quotients
                r.transit_ms  = '0;
                r.speed_mm_s  = '1;
                r.accel_mm_s2 = '1;
                r.zero_time   = 1'b1;
            end else begin
                spd = 64'(spacing_mm) * 64'(pst_pkg::KILO) / 64'(ticks);
                acc = spd * 64'(pst_pkg::KILO) / 64'(ticks);
                r.transit_ms  = TRANSIT_W'(ticks);
                r.speed_mm_s  = spd[SPEED_W-1:0];
                r.accel_mm_s2 = acc[ACCEL_W-1:0];
                r.zero_time   = 1'b0;
            end
            crossings_due.push_back(r);
        end
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            o_errors++;
        end
    endfunction

    // Channel monitor: results are matched before new requests are timed
    always @(posedge i_clk) begin : monitor
        t_crossing want;
        t_crossing got;
        if (!i_rst_n) begin
            thr_first  = pst_pkg::THR1_RST;
            thr_second = pst_pkg::THR2_RST;
            spacing_mm = pst_pkg::SPACING_RST;
            armed      = 1'b0;
            ticks      = '0;
            crossings_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.transit_ms  = i_m_tdata[TRANSIT_W-1:0];
                got.speed_mm_s  = i_m_tdata[TRANSIT_W +: SPEED_W];
                got.accel_mm_s2 = i_m_tdata[TRANSIT_W + SPEED_W +: ACCEL_W];
                got.zero_time   = i_m_tuser[0];
                if (crossings_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got t %0d s %0d a %0d z %0d",
                             $time, got.transit_ms, got.speed_mm_s, got.accel_mm_s2,
                             got.zero_time);
                    o_errors++;
                end else begin
                    want = crossings_due.pop_front();
                    check_field("transit_ms", 64'(want.transit_ms), 64'(got.transit_ms));
                    check_field("speed_mm_s", 64'(want.speed_mm_s), 64'(got.speed_mm_s));
                    check_field("accel_mm_s2", 64'(want.accel_mm_s2), 64'(got.accel_mm_s2));
                    check_field("zero_time", 64'(want.zero_time), 64'(got.zero_time));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pst_pkg::REG_THR1:    thr_first  = i_cfg_data[pst_pkg::THR_W-1:0];
                    pst_pkg::REG_THR2:    thr_second = i_cfg_data[pst_pkg::THR_W-1:0];
                    pst_pkg::REG_SPACING: spacing_mm = i_cfg_data[pst_pkg::SPACING_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                time_crossing(i_s_tdata[SMP_W-1:0], i_s_tdata[SMP_W +: SMP_W]);
        end
        o_pending = crossings_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top of the photogate speed timer: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W = pst_pkg::SAMPLE_BITS_DEF;
    localparam int IN_W  = ((2 * SMP_W + 7) / 8) * 8;
    localparam logic [pst_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [SMP_W-1:0] SMP_MAX = '1;
    localparam int SETTLE_CYCLES = 100;   // longer than one two-quotient detection
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 310;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic [IN_W-1:0]                 s_tdata  = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pst_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            cfg_we   = 1'b0;
    logic [pst_pkg::CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [pst_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int  fail_count;
    int  results_due;
    int  idle_cycles;
    int  sent_items;
    bit  steady_send;
    bit  steady_recv;

    // effective thresholds, used to shape well-formed crossings
    logic [SMP_W-1:0] thr_first_now  = pst_pkg::THR1_RST;
    logic [SMP_W-1:0] thr_second_now = pst_pkg::THR2_RST;

    photogate_speed_timer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    photogate_checker #(.SMP_W(SMP_W), .IN_W(IN_W)) gate_watch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (fail_count),
        .o_pending  (results_due)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no request or result moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink with a random stall before each result
    initial begin : result_sink
        int stall;
        forever begin
            stall = steady_recv ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    function automatic logic [SMP_W-1:0] pick_blocked(input logic [SMP_W-1:0] thr);
        return (thr == '0) ? '0 : SMP_W'($urandom_range(0, thr - 1));
    endfunction

    function automatic logic [SMP_W-1:0] pick_clear(input logic [SMP_W-1:0] thr);
        return SMP_W'($urandom_range(thr, SMP_MAX));
    endfunction

    function automatic logic [SMP_W-1:0] pick_any();
        return SMP_W'($urandom_range(0, SMP_MAX));
    endfunction

    // One sample pair, held until the block takes it
    task automatic send_sample(input logic [SMP_W-1:0] first, input logic [SMP_W-1:0] second);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= IN_W'({second, first});
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // Hold off the sender until every timed crossing has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (results_due != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Reprogram all gate registers once the block is idle
    task automatic program_gates(input logic [pst_pkg::CFG_DATA_W-1:0] thr1,
                                 input logic [pst_pkg::CFG_DATA_W-1:0] thr2,
                                 input logic [pst_pkg::CFG_DATA_W-1:0] spacing);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= pst_pkg::REG_THR1;
        cfg_data <= thr1;
        @(posedge i_clk);
        cfg_idx  <= pst_pkg::REG_THR2;
        cfg_data <= thr2;
        @(posedge i_clk);
        cfg_idx  <= pst_pkg::REG_SPACING;
        cfg_data <= spacing;
        @(posedge i_clk);
        // unmapped index must leave everything alone
        cfg_idx  <= REG_UNUSED;
        cfg_data <= pst_pkg::CFG_DATA_W'($urandom);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        thr_first_now  = thr1[SMP_W-1:0];
        thr_second_now = thr2[SMP_W-1:0];
        @(posedge i_clk);
    endtask

    // Well-formed pass: idle ticks, arm, transit ticks, second gate
    task automatic run_crossing();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 0;
        else if (pick < 96)
            len = $urandom_range(1, 30);
        else
            len = $urandom_range(100, 400);
        repeat ($urandom_range(0, 3)) send_sample(pick_clear(thr_first_now), pick_any());
        if (len == 0) begin
            send_sample(pick_blocked(thr_first_now), pick_blocked(thr_second_now));
        end else begin
            send_sample(pick_blocked(thr_first_now), pick_clear(thr_second_now));
            // first gate is free to toggle while armed
            repeat (len - 1) send_sample(pick_any(), pick_clear(thr_second_now));
            send_sample(pick_any(), pick_blocked(thr_second_now));
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int start_count;
        logic [pst_pkg::CFG_DATA_W-1:0] spacing;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds 720 / 450, spacing 200
        send_sample(SMP_MAX, SMP_MAX);
        send_sample(SMP_MAX, '0);              // second gate while idle
        send_sample('0, '0);                   // both gates on one tick
        send_sample(10'd719, SMP_MAX);         // arm just below threshold
        send_sample(10'd720, 10'd449);         // transit of one tick
        send_sample('0, SMP_MAX);
        send_sample('0, SMP_MAX);              // first gate again while armed
        send_sample(SMP_MAX, 10'd450);         // second exactly at threshold
        send_sample(SMP_MAX, '0);
        send_sample(10'd500, 10'd500);
        send_sample('0, '0);

        // upper data bits must be masked off; widest spacing
        program_gates(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(10'd1022, SMP_MAX);
        send_sample(SMP_MAX, 10'd1022);
        send_sample(SMP_MAX, 10'd1022);

        // thresholds of zero: nothing can block
        program_gates(16'h0000, 16'h0000, 16'd1);
        send_sample('0, '0);
        send_sample('0, '0);

        // spacing of zero
        program_gates(16'd512, 16'd512, 16'd0);
        send_sample('0, SMP_MAX);
        send_sample(SMP_MAX, '0);
        send_sample('0, '0);

        program_gates(16'd512, 16'd512, 16'd1);
        send_sample('0, SMP_MAX);
        send_sample(SMP_MAX, SMP_MAX);
        send_sample(SMP_MAX, '0);

        // random settings, mostly well-formed crossings with some noise
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       spacing = 16'd1;
                1:       spacing = 16'hFFFF;
                default: spacing = pst_pkg::CFG_DATA_W'($urandom);
            endcase
            program_gates({6'($urandom), 10'($urandom_range(1, 1023))},
                          {6'($urandom), 10'($urandom_range(1, 1023))}, spacing);
            start_count = sent_items;
            while (sent_items - start_count < PHASE_ITEMS) begin
                steady_send = ($urandom_range(0, 4) == 0);
                steady_recv = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 5)) send_sample(pick_any(), pick_any());
                else
                    run_crossing();
                if ($urandom_range(0, 24) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
